### sv/lsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Lagrange shape weight block.
// No dependencies; imported by every module of the block.
package lsw_pkg;

  localparam int MAX_ORDER   = 7;
  localparam int ORDER_W     = 3;
  localparam int IDX_W       = 6;
  localparam int MAG_W       = 33;  // magnitude saturates at 2^32
  localparam int WEIGHT_W    = 32;
  localparam int WEIGHT_FRAC = 24;
  localparam int DEN_W       = 3;
  localparam int DIV_W       = 40;
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;
  localparam int QDEPTH      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_ORDER    = 2'd1;

  typedef enum logic {SHAPE_TRI, SHAPE_QUAD} shape_e;
  typedef enum logic [1:0] {PH_U, PH_V, PH_W} phase_e;
  typedef enum logic [1:0] {BK_IDLE, BK_SEL, BK_WAIT, BK_OUT} back_st_e;
  typedef enum logic [1:0] {FU_IDLE, FU_MUL, FU_DIV} fac_st_e;

  typedef struct packed {
    logic                 last;
    shape_e               shape;
    logic [ORDER_W-1:0]   order;
  } item_ctl_t;

endpackage

### sv/lsw_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, item intake and a short item queue.
// Depends on lsw_pkg.
module lsw_front #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lsw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [COORD_FRAC_BITS:0]          u_coord_i,
  input  logic [COORD_FRAC_BITS:0]          v_coord_i,
  input  logic                              last_point_i,
  input  logic                              pop_i,
  output logic                              head_valid_o,
  output lsw_pkg::item_ctl_t                head_ctl_o,
  output logic [COORD_FRAC_BITS:0]          head_u_o,
  output logic [COORD_FRAC_BITS:0]          head_v_o,
  output logic signed [COORD_FRAC_BITS+2:0] head_w_o
);
  import lsw_pkg::*;

  localparam int CW    = COORD_FRAC_BITS + 1;
  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [CW+1:0] ONE_FX = (CW+2)'(1) << COORD_FRAC_BITS;

  shape_e               shape_q;
  logic [ORDER_W-1:0]   order_q;
  item_ctl_t            ctl_q [QDEPTH];
  logic [CW-1:0]        u_q [QDEPTH];
  logic [CW-1:0]        v_q [QDEPTH];
  logic signed [CW+1:0] w_q [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     count_q;
  logic                 push;
  item_ctl_t            ctl_in;
  logic signed [CW+1:0] w_in;

  assign cfg_ready_o  = 1'b1;
  assign busy_o       = (count_q == CNT_W'(QDEPTH));
  assign push         = start_i && !busy_o;
  assign head_valid_o = (count_q != '0);
  assign head_ctl_o   = ctl_q[rd_ptr_q];
  assign head_u_o     = u_q[rd_ptr_q];
  assign head_v_o     = v_q[rd_ptr_q];
  assign head_w_o     = w_q[rd_ptr_q];

  // w = 1 - u - v, exact and signed
  assign w_in = $signed(ONE_FX - {2'b00, u_coord_i} - {2'b00, v_coord_i});

  always_comb begin
    ctl_in.last  = last_point_i;
    ctl_in.shape = shape_q;
    ctl_in.order = (order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_TRI;
      order_q <= ORDER_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ELEMENT_SHAPE: shape_q <= shape_e'(cfg_data_i[0]);
        CFG_POLY_ORDER:    order_q <= cfg_data_i[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q] <= ctl_in;
      u_q[wr_ptr_q]   <= u_coord_i;
      v_q[wr_ptr_q]   <= v_coord_i;
      w_q[wr_ptr_q]   <= w_in;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QDEPTH))
    else $error("item queue over-filled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("item popped from empty queue");
`endif

endmodule

### sv/lsw_factor.sv
`timescale 1ns / 1ps
// Factor unit: mag * num, rounded, divided by d * 2^F in byte-wise steps.
// Depends on lsw_pkg.
module lsw_factor #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int NM_W            = 21
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [lsw_pkg::MAG_W-1:0]   mag_i,
  input  logic [NM_W-1:0]             nm_i,
  input  logic [lsw_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [lsw_pkg::MAG_W-1:0]   mag_o
);
  import lsw_pkg::*;

  localparam int PROD_W = MAG_W + NM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [DIV_W-1:0] MAG_LIMIT = DIV_W'(1) << (MAG_W - 1);

  fac_st_e              st_q, st_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [SUM_W-1:0]     sum;

  assign sum    = {1'b0, prod_q} + (SUM_W'(den_q) << (COORD_FRAC_BITS - 1));
  assign done_o = done_q;
  assign mag_o  = (quo_q > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : quo_q[MAG_W-1:0];

  always_comb begin
    logic [DIV_W-1:0] q;
    logic [DEN_W-1:0] r;
    logic [DEN_W:0]   r4;
    st_d   = st_q;
    prod_d = prod_q;
    den_d  = den_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    q      = quo_q;
    r      = rem_q;
    r4     = '0;
    unique case (st_q)
      FU_IDLE: begin
        if (go_i) begin
          prod_d = mag_i * nm_i;
          den_d  = den_i;
          st_d   = FU_MUL;
        end
      end
      FU_MUL: begin
        quo_d = DIV_W'(sum >> COORD_FRAC_BITS);
        rem_d = '0;
        cnt_d = '0;
        st_d  = FU_DIV;
      end
      FU_DIV: begin
        // restoring division, one byte of quotient per cycle
        for (int j = 0; j < DIV_BITS; j++) begin
          r4 = {r, q[DIV_W-1]};
          q  = {q[DIV_W-2:0], 1'b0};
          if (r4 >= {1'b0, den_q}) begin
            r4   = r4 - {1'b0, den_q};
            q[0] = 1'b1;
          end
          r = r4[DEN_W-1:0];
        end
        quo_d = q;
        rem_d = r;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          done_d = 1'b1;
          st_d   = FU_IDLE;
        end
      end
      default: st_d = FU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FU_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

`ifndef SYNTH
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> (st_q == FU_IDLE) && !done_q)
    else $error("factor launched while unit busy");
`endif

endmodule

### sv/lsw_back.sv
`timescale 1ns / 1ps
// Back end: walks the nodes and factors of the head item and emits weights.
// Depends on lsw_pkg and lsw_factor.
module lsw_back #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  lsw_pkg::item_ctl_t                head_ctl_i,
  input  logic [COORD_FRAC_BITS:0]          head_u_i,
  input  logic [COORD_FRAC_BITS:0]          head_v_i,
  input  logic signed [COORD_FRAC_BITS+2:0] head_w_i,
  output logic                              pop_o,
  output logic                              result_valid_o,
  output logic signed [lsw_pkg::WEIGHT_W-1:0] weight_o,
  output logic [lsw_pkg::IDX_W-1:0]         node_index_o,
  output logic                              last_node_o,
  output logic                              batch_end_o
);
  import lsw_pkg::*;

  localparam int CW    = COORD_FRAC_BITS + 1;
  localparam int NUM_W = COORD_FRAC_BITS + 6;
  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << WEIGHT_FRAC;

  back_st_e            st_q, st_d;
  phase_e              ph_q, ph_d;
  logic [ORDER_W-1:0]  a_q, a_d, b_q, b_d;
  logic [ORDER_W:0]    i_q, i_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic                neg_q, neg_d;
  logic                res_valid_q, res_valid_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                last_node_q, last_node_d;
  logic                batch_end_q, batch_end_d;

  logic [ORDER_W-1:0]      n, c, atop, k;
  logic                    is_tri;
  logic signed [NUM_W-1:0] xs, nx, io, num, nm_abs;
  logic signed [ORDER_W+1:0] dk;
  logic [DEN_W-1:0]        den;
  logic                    fac_go, fac_done, node_last;
  logic [MAG_W-1:0]        fac_mag;

  function automatic logic [WEIGHT_W-1:0] to_q724(logic [MAG_W-1:0] m, logic s);
    logic [WEIGHT_W-1:0] r;
    if (m == '0) begin
      r = '0;
    end else if (!s) begin
      r = m[MAG_W-1] ? {1'b0, {(WEIGHT_W-1){1'b1}}} : (m[WEIGHT_W-1] ?
          {1'b0, {(WEIGHT_W-1){1'b1}}} : m[WEIGHT_W-1:0]);
    end else if (m[MAG_W-1] || m[WEIGHT_W-1]) begin
      r = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      r = -m[WEIGHT_W-1:0];
    end
    return r;
  endfunction

  assign n         = head_ctl_i.order;
  assign is_tri    = (head_ctl_i.shape == SHAPE_TRI);
  assign c         = n - a_q - b_q;
  assign atop      = is_tri ? (n - b_q) : n;
  assign node_last = (b_q == n) && (a_q == atop);

  always_comb begin
    case (ph_q)
      PH_U: begin
        k  = a_q;
        xs = $signed({{(NUM_W-CW){1'b0}}, head_u_i});
      end
      PH_V: begin
        k  = b_q;
        xs = $signed({{(NUM_W-CW){1'b0}}, head_v_i});
      end
      default: begin
        k  = c;
        xs = $signed({{(NUM_W-CW-2){head_w_i[CW+1]}}, head_w_i});
      end
    endcase
  end

  // factor (N*x - i) / (k - i), numerator scaled by 2^F
  assign nx     = xs * $signed({{(NUM_W-ORDER_W){1'b0}}, n});
  assign io     = $signed(NUM_W'(i_q) << COORD_FRAC_BITS);
  assign num    = nx - io;
  assign nm_abs = num[NUM_W-1] ? -num : num;
  assign dk     = $signed({2'b00, k}) - $signed({1'b0, i_q});
  assign den    = dk[ORDER_W+1] ? DEN_W'(-dk) : dk[DEN_W-1:0];

  always_comb begin
    st_d        = st_q;
    ph_d        = ph_q;
    a_d         = a_q;
    b_d         = b_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    res_valid_d = 1'b0;
    weight_d    = weight_q;
    idx_d       = idx_q;
    last_node_d = last_node_q;
    batch_end_d = batch_end_q;
    fac_go      = 1'b0;
    pop_o       = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          a_d   = '0;
          b_d   = '0;
          cnt_d = '0;
          mag_d = MAG_ONE;
          neg_d = 1'b0;
          ph_d  = PH_U;
          i_d   = '0;
          st_d  = BK_SEL;
        end
      end
      BK_SEL: begin
        if (is_tri) begin
          if ({1'b0, k} > i_q) begin
            fac_go = 1'b1;
          end else if (ph_q == PH_W) begin
            st_d = BK_OUT;
          end else begin
            ph_d = (ph_q == PH_U) ? PH_V : PH_W;
            i_d  = '0;
          end
        end else begin
          if (i_q > {1'b0, n}) begin
            if (ph_q == PH_V) begin
              st_d = BK_OUT;
            end else begin
              ph_d = PH_V;
              i_d  = '0;
            end
          end else if (i_q == {1'b0, k}) begin
            i_d = i_q + 1'b1;
          end else begin
            fac_go = 1'b1;
          end
        end
        if (fac_go) begin
          neg_d = neg_q ^ num[NUM_W-1] ^ dk[ORDER_W+1];
          st_d  = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (fac_done) begin
          mag_d = fac_mag;
          i_d   = i_q + 1'b1;
          st_d  = BK_SEL;
        end
      end
      BK_OUT: begin
        res_valid_d = 1'b1;
        weight_d    = to_q724(mag_q, neg_q);
        idx_d       = cnt_q;
        last_node_d = node_last;
        batch_end_d = node_last && head_ctl_i.last;
        if (node_last) begin
          pop_o = 1'b1;
          st_d  = BK_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          if (a_q == atop) begin
            a_d = '0;
            b_d = b_q + 1'b1;
          end else begin
            a_d = a_q + 1'b1;
          end
          mag_d = MAG_ONE;
          neg_d = 1'b0;
          ph_d  = PH_U;
          i_d   = '0;
          st_d  = BK_SEL;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  lsw_factor #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .NM_W            (NUM_W - 1)
  ) u_factor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (fac_go),
    .mag_i  (mag_q),
    .nm_i   (nm_abs[NUM_W-2:0]),
    .den_i  (den),
    .done_o (fac_done),
    .mag_o  (fac_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q        <= ph_d;
    a_q         <= a_d;
    b_q         <= b_d;
    i_q         <= i_d;
    cnt_q       <= cnt_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    weight_q    <= weight_d;
    idx_q       <= idx_d;
    last_node_q <= last_node_d;
    batch_end_q <= batch_end_d;
  end

  assign result_valid_o = res_valid_q;
  assign weight_o       = $signed(weight_q);
  assign node_index_o   = idx_q;
  assign last_node_o    = last_node_q;
  assign batch_end_o    = batch_end_q;

`ifndef SYNTH
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("weights issued on consecutive cycles");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && batch_end_o |-> last_node_o)
    else $error("batch end without last node");
  a_pop_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> result_valid_o && last_node_o)
    else $error("item retired without its last weight");
`endif

endmodule

### sv/lagrange_shape_weights_top.sv
`timescale 1ns / 1ps
// Top level of the Lagrange shape weight block.
// Depends on lsw_pkg, lsw_front and lsw_back.
//
// Each accepted point (start_i high, busy_o low) yields one weight per node,
// v index outer, u index inner, each on the result ports for one cycle with
// result_valid_o; the receiver cannot stall. A two-item queue takes points
// while the back end works. One shared factor unit (multiply, round, then a
// byte-wise divide by the node denominator) sets the pace: the back end
// waits for each factor before it selects the next; a node also passes
// through phase changes, skipped indices and its output, and each point
// passes through idle. The first weight leaves in the cycle after its node
// completes. Configuration writes are always ready.
module lagrange_shape_weights_top #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lsw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [COORD_FRAC_BITS:0]            u_coord_i,
  input  logic [COORD_FRAC_BITS:0]            v_coord_i,
  input  logic                                last_point_i,
  output logic                                result_valid_o,
  output logic signed [lsw_pkg::WEIGHT_W-1:0] weight_o,
  output logic [lsw_pkg::IDX_W-1:0]           node_index_o,
  output logic                                last_node_o,
  output logic                                batch_end_o
);
  import lsw_pkg::*;

  logic                              head_valid, pop;
  item_ctl_t                         head_ctl;
  logic [COORD_FRAC_BITS:0]          head_u, head_v;
  logic signed [COORD_FRAC_BITS+2:0] head_w;

  lsw_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .last_point_i (last_point_i),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_ctl_o   (head_ctl),
    .head_u_o     (head_u),
    .head_v_o     (head_v),
    .head_w_o     (head_w)
  );

  lsw_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_ctl_i     (head_ctl),
    .head_u_i       (head_u),
    .head_v_i       (head_v),
    .head_w_i       (head_w),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .weight_o       (weight_o),
    .node_index_o   (node_index_o),
    .last_node_o    (last_node_o),
    .batch_end_o    (batch_end_o)
  );

endmodule
